// File: rtl/cfu_pkg.sv
// types, constants and decode functions shared by the clock face led updater
`timescale 1ns / 1ps

package cfu_pkg;

  localparam int unsigned LED_COUNT  = 60;
  localparam int unsigned MAX_WRITES = 6;

  typedef logic [23:0] color_t;
  typedef logic [5:0]  pos_t;
  typedef logic [2:0]  wr_cnt_t;

  typedef enum logic [1:0] {
    REG_HOUR,
    REG_MINUTE,
    REG_SECOND,
    REG_BACKGROUND
  } reg_idx_e;

  typedef struct packed {
    color_t hour;
    color_t minute;
    color_t second;
    color_t background;
  } colors_t;

  typedef struct packed {
    pos_t   index;
    color_t color;
  } led_wr_t;

  // minute or second bcd to binary, clamped to 59
  function automatic pos_t ms_position(logic [6:0] bcd);
    logic [6:0] bin;
    bin = 7'(bcd[6:4]) * 7'd10 + 7'(bcd[3:0]);
    if (bin > 7'd59) begin
      bin = 7'd59;
    end
    return bin[5:0];
  endfunction

  // hour bcd to hand position, (hour mod 12) * 5
  function automatic pos_t hour_position(logic [5:0] bcd);
    logic [5:0] bin;
    bin = 6'(bcd[5:4]) * 6'd10 + 6'(bcd[3:0]);
    if (bin >= 6'd36) begin
      bin = bin - 6'd36;
    end else if (bin >= 6'd24) begin
      bin = bin - 6'd24;
    end else if (bin >= 6'd12) begin
      bin = bin - 6'd12;
    end
    return bin * 6'd5;
  endfunction

  // mirrored physical led number
  function automatic pos_t mirror(pos_t p);
    return (p == '0) ? '0 : pos_t'(LED_COUNT) - p;
  endfunction

endpackage

// File: rtl/cfu_if.sv
// valid/ready channels for time readings and led writes
`timescale 1ns / 1ps

interface cfu_time_if;
  logic       valid;
  logic       ready;
  logic [5:0] hour_bcd;
  logic [6:0] minute_bcd;
  logic [6:0] second_bcd;

  modport source (output valid, hour_bcd, minute_bcd, second_bcd, input ready);
  modport sink   (input valid, hour_bcd, minute_bcd, second_bcd, output ready);
endinterface

interface cfu_led_if;
  logic        valid;
  logic        ready;
  logic [5:0]  led_index;
  logic [23:0] led_color;
  logic        last_write;

  modport source (output valid, led_index, led_color, last_write, input ready);
  modport sink   (input valid, led_index, led_color, last_write, output ready);
endinterface

// File: rtl/cfu_apb_regs.sv
// apb colour registers of the clock face led updater
`timescale 1ns / 1ps

module cfu_apb_regs (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [3:0]       paddr,
  input  logic [31:0]      pwdata,
  output logic [31:0]      prdata,
  output logic             pready,
  output cfu_pkg::colors_t colors_o
);
  import cfu_pkg::*;

  colors_t  colors_q, colors_d;
  reg_idx_e idx;
  logic     wr_en;

  assign idx    = reg_idx_e'(paddr[3:2]);
  assign wr_en  = psel & penable & pwrite;
  assign pready = 1'b1;

  always_comb begin
    colors_d = colors_q;
    if (wr_en) begin
      unique case (idx)
        REG_HOUR:       colors_d.hour       = pwdata[23:0];
        REG_MINUTE:     colors_d.minute     = pwdata[23:0];
        REG_SECOND:     colors_d.second     = pwdata[23:0];
        REG_BACKGROUND: colors_d.background = pwdata[23:0];
        default:        colors_d = colors_q;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_HOUR:       prdata = {8'h00, colors_q.hour};
      REG_MINUTE:     prdata = {8'h00, colors_q.minute};
      REG_SECOND:     prdata = {8'h00, colors_q.second};
      REG_BACKGROUND: prdata = {8'h00, colors_q.background};
      default:        prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      colors_q.hour       <= 24'hFF0000;
      colors_q.minute     <= 24'h00FF00;
      colors_q.second     <= 24'h0000FF;
      colors_q.background <= 24'h000000;
    end else begin
      colors_q <= colors_d;
    end
  end

  assign colors_o = colors_q;

endmodule

// File: rtl/clock_face_led_updater.sv
// top level of the clock face led updater
//
//   channel  dir  carries                              handshake
//   time_i   in   hour_bcd, minute_bcd, second_bcd     valid/ready
//   led_o    out  led_index, led_color, last_write     valid/ready
//   apb      in   colour registers at 0x0, 0x4, 0x8, 0xc   psel/penable, pready high
//
// a reading passes an input register, is planned combinationally into 2 to 6
// led writes for the write queue, and the writes leave one a cycle through the
// output register while led_o is ready; the queue sets the rate: a reading waits
// in the input register and enters the queue as the previous last write leaves it
// reset clears hand positions, toggle flag, queue count and valid flags
`timescale 1ns / 1ps

module clock_face_led_updater (
  input  logic        clk_i,
  input  logic        rst_ni,
  cfu_time_if.sink    time_i,
  cfu_led_if.source   led_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import cfu_pkg::*;

  colors_t colors;

  cfu_apb_regs u_regs (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .colors_o (colors)
  );

  // input register
  logic       in_valid_q;
  logic [5:0] hour_bcd_q;
  logic [6:0] minute_bcd_q;
  logic [6:0] second_bcd_q;

  // hand state
  pos_t hour_pos_q, minute_pos_q, second_pos_q;
  logic show_minute_q;

  // write queue
  led_wr_t slot_q [MAX_WRITES];
  wr_cnt_t cnt_q;

  // output register
  logic    out_valid_q;
  led_wr_t out_q;
  logic    out_last_q;

  logic    out_load, job_load, in_take;
  pos_t    h, m, s;
  logic    coincide;
  logic [MAX_WRITES-1:0] en;
  led_wr_t cand [MAX_WRITES];
  led_wr_t list [MAX_WRITES];
  wr_cnt_t k;

  assign out_load = (cnt_q != '0) && (!out_valid_q || led_o.ready);
  assign job_load = in_valid_q && ((cnt_q == '0) || ((cnt_q == 3'd1) && out_load));
  assign time_i.ready = !in_valid_q || job_load;
  assign in_take  = time_i.valid && time_i.ready;

  assign h = hour_position(hour_bcd_q);
  assign m = ms_position(minute_bcd_q);
  assign s = ms_position(second_bcd_q);
  assign coincide = (h == m);

  always_comb begin
    en[0]   = (h != hour_pos_q);
    en[1]   = (m != minute_pos_q);
    en[2]   = (s != second_pos_q);
    en[3]   = 1'b1;
    en[4]   = !coincide;
    en[5]   = 1'b1;
    cand[0] = '{index: mirror(hour_pos_q),   color: colors.background};
    cand[1] = '{index: mirror(minute_pos_q), color: colors.background};
    cand[2] = '{index: mirror(second_pos_q), color: colors.background};
    if (coincide) begin
      cand[3] = '{index: mirror(m),
                  color: show_minute_q ? colors.minute : colors.hour};
    end else begin
      cand[3] = '{index: mirror(h), color: colors.hour};
    end
    cand[4] = '{index: mirror(m), color: colors.minute};
    cand[5] = '{index: mirror(s), color: colors.second};
    k = '0;
    for (int i = 0; i < MAX_WRITES; i++) begin
      list[i] = '0;
    end
    for (int i = 0; i < MAX_WRITES; i++) begin
      if (en[i]) begin
        list[k] = cand[i];
        k       = k + 3'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q    <= 1'b0;
      hour_pos_q    <= '0;
      minute_pos_q  <= '0;
      second_pos_q  <= '0;
      show_minute_q <= 1'b0;
      cnt_q         <= '0;
      out_valid_q   <= 1'b0;
    end else begin
      if (in_take) begin
        in_valid_q <= 1'b1;
      end else if (job_load) begin
        in_valid_q <= 1'b0;
      end
      if (job_load) begin
        hour_pos_q   <= h;
        minute_pos_q <= m;
        second_pos_q <= s;
        if (coincide) begin
          show_minute_q <= !show_minute_q;
        end
        cnt_q <= k;
      end else if (out_load) begin
        cnt_q <= cnt_q - 3'd1;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (led_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      hour_bcd_q   <= time_i.hour_bcd;
      minute_bcd_q <= time_i.minute_bcd;
      second_bcd_q <= time_i.second_bcd;
    end
    if (job_load) begin
      for (int i = 0; i < MAX_WRITES; i++) begin
        slot_q[i] <= list[i];
      end
    end else if (out_load) begin
      for (int i = 0; i < MAX_WRITES - 1; i++) begin
        slot_q[i] <= slot_q[i+1];
      end
    end
    if (out_load) begin
      out_q      <= slot_q[0];
      out_last_q <= (cnt_q == 3'd1);
    end
  end

  assign led_o.valid      = out_valid_q;
  assign led_o.led_index  = out_q.index;
  assign led_o.led_color  = out_q.color;
  assign led_o.last_write = out_last_q;

endmodule
